>>> rtl/core/rksr_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed stepping rotor: function and register codes,
// build sequencer states and the structs passed between the modules.
// No dependencies.
package rksr_pkg;

	localparam int BYTE_W      = 8;
	localparam int PERM_DEPTH  = 256;
	localparam int KEY_MAX_DEF = 256;
	localparam int CNT_W       = 16;
	localparam int KLEN_W      = 9;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	localparam logic [BYTE_W-1:0] PERM_LAST = 8'hFF;

	localparam logic [1:0] FN_LOAD_KEY = 2'd0;
	localparam logic [1:0] FN_BUILD    = 2'd1;
	localparam logic [1:0] FN_PROCESS  = 2'd2;

	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_KEY_LEN   = 2'd1;
	localparam logic [1:0] REG_BYTES_MOV = 2'd2;
	localparam logic [1:0] REG_STEP      = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD,
		ST_KS_J,
		ST_KS_WI,
		ST_KS_WJ,
		ST_INV,
		ST_INV_END
	} build_state_t;

	typedef struct packed {
		logic              mode_decrypt;
		logic [KLEN_W-1:0] key_length;
		logic [CNT_W-1:0]  bytes_per_move;
		logic [BYTE_W-1:0] step_size;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [BYTE_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic [BYTE_W-1:0] raddr;
	} perm_req_t;

	typedef struct packed {
		logic              we;
		logic [BYTE_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
	} scr_wr_t;

endpackage

>>> rtl/core/rksr_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module rksr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/rksr_cfg.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on rksr_pkg.
module rksr_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rksr_pkg::APB_AW-1:0] paddr,
	input  logic [rksr_pkg::APB_DW-1:0] pwdata,
	output logic [rksr_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output rksr_pkg::cfg_t             cfg
);
	import rksr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_decrypt   <= 1'b0;
			cfg_q.key_length     <= KLEN_W'(1);
			cfg_q.bytes_per_move <= CNT_W'(1);
			cfg_q.step_size      <= BYTE_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:      cfg_q.mode_decrypt   <= pwdata[0];
				REG_KEY_LEN:   cfg_q.key_length     <= pwdata[KLEN_W-1:0];
				REG_BYTES_MOV: cfg_q.bytes_per_move <= pwdata[CNT_W-1:0];
				REG_STEP:      cfg_q.step_size      <= pwdata[BYTE_W-1:0];
				default:       cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:      prdata = APB_DW'(cfg_q.mode_decrypt);
			REG_KEY_LEN:   prdata = APB_DW'(cfg_q.key_length);
			REG_BYTES_MOV: prdata = APB_DW'(cfg_q.bytes_per_move);
			REG_STEP:      prdata = APB_DW'(cfg_q.step_size);
			default:       prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/rksr_sched.sv
`timescale 1ns / 1ps
// Build sequencer: fills the permutation, runs the key schedule through the
// permutation and key memories, and writes the inverse table when decrypting.
// Depends on rksr_pkg.
module rksr_sched #(
	parameter int KEY_MAX = rksr_pkg::KEY_MAX_DEF,
	parameter int KA_W    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         build_start,
	input  rksr_pkg::cfg_t               cfg,
	input  logic [rksr_pkg::BYTE_W-1:0]  perm_rdata,
	input  logic [rksr_pkg::BYTE_W-1:0]  key_rdata,
	output logic                         busy,
	output logic                         table_inv,
	output rksr_pkg::perm_req_t          perm_req,
	output rksr_pkg::scr_wr_t            scr_wr,
	output logic [KA_W-1:0]              key_raddr
);
	import rksr_pkg::*;

	localparam logic [KLEN_W-1:0] KEY_MAX_L = KLEN_W'(KEY_MAX);

	build_state_t      state_q, state_d;
	logic [BYTE_W-1:0] i_q, j_q, pi_q, inv_idx_s1;
	logic              inv_v_s1, table_inv_q;
	logic [KA_W-1:0]   kpos_q;
	logic [KLEN_W-1:0] len_eff, len_m1;
	logic [BYTE_W-1:0] j_next;
	logic              i_last;

	assign len_eff   = (cfg.key_length == '0 || cfg.key_length > KEY_MAX_L) ?
		KEY_MAX_L : cfg.key_length;
	assign len_m1    = len_eff - KLEN_W'(1);
	assign j_next    = j_q + perm_rdata + key_rdata;
	assign i_last    = (i_q == PERM_LAST);
	assign table_inv = table_inv_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (build_start) state_d = ST_INIT;
			ST_INIT:    if (i_last) state_d = ST_KS_RD;
			ST_KS_RD:   state_d = ST_KS_J;
			ST_KS_J:    state_d = ST_KS_WI;
			ST_KS_WI:   state_d = ST_KS_WJ;
			ST_KS_WJ: begin
				if (!i_last) begin
					state_d = ST_KS_RD;
				end else if (cfg.mode_decrypt) begin
					state_d = ST_INV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_INV:     if (i_last) state_d = ST_INV_END;
			ST_INV_END: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy           = (state_q != ST_IDLE);
		perm_req.we    = 1'b0;
		perm_req.waddr = i_q;
		perm_req.wdata = i_q;
		perm_req.raddr = i_q;
		key_raddr      = kpos_q;
		case (state_q)
			ST_INIT:  perm_req.we = 1'b1;
			ST_KS_J:  perm_req.raddr = j_next;
			ST_KS_WI: begin
				perm_req.we    = 1'b1;
				perm_req.wdata = perm_rdata;
			end
			ST_KS_WJ: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = j_q;
				perm_req.wdata = pi_q;
			end
			default:  perm_req.we = 1'b0;
		endcase
		scr_wr.we    = inv_v_s1;
		scr_wr.waddr = perm_rdata;
		scr_wr.wdata = inv_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			kpos_q      <= '0;
			inv_v_s1    <= 1'b0;
			table_inv_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			inv_v_s1 <= (state_q == ST_INV);
			case (state_q)
				ST_IDLE: begin
					i_q    <= '0;
					j_q    <= '0;
					kpos_q <= '0;
					if (build_start) begin
						table_inv_q <= cfg.mode_decrypt;
					end
				end
				ST_INIT:  i_q <= i_q + BYTE_W'(1);
				ST_KS_J:  j_q <= j_next;
				ST_KS_WJ: begin
					i_q <= i_q + BYTE_W'(1);
					if (KLEN_W'(kpos_q) == len_m1) begin
						kpos_q <= '0;
					end else begin
						kpos_q <= kpos_q + KA_W'(1);
					end
				end
				ST_INV:   i_q <= i_q + BYTE_W'(1);
				default:  i_q <= i_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_KS_J) begin
			pi_q <= perm_rdata;
		end
		inv_idx_s1 <= i_q;
	end

endmodule

>>> rtl/core/rc4_keyed_stepping_rotor_top.sv
`timescale 1ns / 1ps
// Top level of the keyed stepping rotor: key memory, a table memory with the permutation
// in its lower half and the inverse in its upper half, substitution path and config port.
// Depends on rksr_pkg, rksr_ram, rksr_cfg and rksr_sched.
//
//   Channel   Handshake             Payload
//   command   start / busy          func, key_index, data_byte
//   result    done (one-cycle)      out_byte
//   config    APB psel/penable      paddr, pwdata, prdata, pready
//
// A data byte is taken every cycle while busy is low; its result follows in
// the next cycle, from the registered read of the table memory.
// A build holds busy while it fills the permutation, runs the key schedule
// on the single permutation port and, in decrypt mode, writes the inverse table.
// After reset the offset and byte counter are zero; tables are unset.
// Results cannot be stalled by the receiver.
module rc4_keyed_stepping_rotor_top #(
	parameter int KEY_MAX = rksr_pkg::KEY_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [7:0]                  key_index,
	input  logic [7:0]                  data_byte,
	output logic                        done,
	output logic [7:0]                  out_byte,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rksr_pkg::APB_AW-1:0] paddr,
	input  logic [rksr_pkg::APB_DW-1:0] pwdata,
	output logic [rksr_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import rksr_pkg::*;

	localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam logic [KLEN_W-1:0] KEY_MAX_L = KLEN_W'(KEY_MAX);

	cfg_t              cfg;
	perm_req_t         perm_req;
	scr_wr_t           scr_wr;
	logic              table_inv, accept, do_proc, do_build, do_key;
	logic [KA_W-1:0]   key_raddr;
	logic [BYTE_W-1:0] tab_rdata, key_rdata, tab_addr, tab_wdata;
	logic [BYTE_W:0]   tab_waddr, tab_raddr;
	logic              tab_we;
	logic [BYTE_W-1:0] offset_q, off_s1;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W:0]    cnt_next, cnt_limit;
	logic              done_s1, dec_s1;

	assign accept   = start & ~busy;
	assign do_proc  = accept && (func == FN_PROCESS);
	assign do_build = accept && (func == FN_BUILD);
	assign do_key   = accept && (func == FN_LOAD_KEY) && ({1'b0, key_index} < KEY_MAX_L);

	assign tab_addr  = cfg.mode_decrypt ? data_byte : data_byte + offset_q;
	assign tab_we    = perm_req.we | scr_wr.we;
	assign tab_waddr = scr_wr.we ? {1'b1, scr_wr.waddr} : {1'b0, perm_req.waddr};
	assign tab_wdata = scr_wr.we ? scr_wr.wdata : perm_req.wdata;
	assign tab_raddr = busy ? {1'b0, perm_req.raddr} : {table_inv, tab_addr};

	rksr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rksr_sched #(
		.KEY_MAX (KEY_MAX)
	) u_sched (
		.clk         (clk),
		.arst_n      (arst_n),
		.build_start (do_build),
		.cfg         (cfg),
		.perm_rdata  (tab_rdata),
		.key_rdata   (key_rdata),
		.busy        (busy),
		.table_inv   (table_inv),
		.perm_req    (perm_req),
		.scr_wr      (scr_wr),
		.key_raddr   (key_raddr)
	);

	rksr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (KEY_MAX)
	) u_key_ram (
		.clk   (clk),
		.we    (do_key),
		.waddr (key_index[KA_W-1:0]),
		.wdata (data_byte),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	rksr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (2 * PERM_DEPTH)
	) u_tab_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	assign cnt_next  = {1'b0, cnt_q} + (CNT_W+1)'(1);
	assign cnt_limit = (cfg.bytes_per_move == '0) ? {1'b1, {CNT_W{1'b0}}} :
		{1'b0, cfg.bytes_per_move};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			cnt_q    <= '0;
			done_s1  <= 1'b0;
		end else begin
			done_s1 <= do_proc;
			if (do_build) begin
				offset_q <= '0;
				cnt_q    <= '0;
			end else if (do_proc) begin
				if (cnt_next >= cnt_limit) begin
					offset_q <= offset_q + cfg.step_size;
					cnt_q    <= '0;
				end else begin
					cnt_q <= cnt_next[CNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_proc) begin
			off_s1 <= offset_q;
			dec_s1 <= cfg.mode_decrypt;
		end
	end

	assign out_byte = dec_s1 ? tab_rdata - off_s1 : tab_rdata;
	assign done     = done_s1;

endmodule

>>> rtl/core/rksr_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the keyed stepping rotor top level, with its bind.
// Depends on rksr_pkg and rc4_keyed_stepping_rotor_top.
module rksr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic       done,
	input logic       pready
);
	import rksr_pkg::*;

	a_done_only_after_process: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && func == FN_PROCESS))
		else $error("Result strobe without a preceding process transaction.");

	a_process_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_PROCESS) |=> done)
		else $error("Process transaction gave no result.");

	a_build_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_BUILD) |=> busy)
		else $error("Build transaction did not raise busy.");

	a_no_result_for_key: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_LOAD_KEY) |=> !done)
		else $error("Key load transaction produced a result.");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("Configuration port stalled.");

endmodule

bind rc4_keyed_stepping_rotor_top rksr_chk u_rksr_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.func   (func),
	.done   (done),
	.pready (pready)
);
